// File: rtl/core/ovn_pkg.sv
// Shared types and constants for the octave value noise block.
// Holds datapath widths, config register indexes and the ctrl/status structs.
package ovn_pkg;

  localparam int SEED_W = 16;
  localparam int GAIN_W = 16;
  localparam int OCT_W  = 3;
  localparam int WGT_W  = 37;  // per-octave weight, Q.12
  localparam int ACC_W  = 56;  // sum of value*weight
  localparam int WS_W   = 40;  // sum of weights
  localparam int QUO_W  = 16;  // quotient bits of the normalizing divide
  localparam int FRAC_SH = 12;

  localparam logic [WGT_W-1:0] WGT_ONE      = WGT_W'(4096);
  localparam logic [OCT_W-1:0] OCT_CNT_RST  = OCT_W'(1);
  localparam logic [GAIN_W-1:0] OCT_GAIN_RST = GAIN_W'(2048);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic {
    CFG_OCT_COUNT = 1'b0,
    CFG_OCT_GAIN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LERP_TOP = 2'd0,
    LERP_BOT = 2'd1,
    LERP_VER = 2'd2,
    LERP_NOP = 2'd3
  } lerp_sel_e;

  typedef struct packed {
    logic      seed_we;
    logic      q_load;
    logic      rd_en;
    logic [1:0] rd_sel;
    logic      cap_en;
    logic [1:0] cap_sel;
    logic      lerp_en;
    lerp_sel_e lerp_sel;
    logic      mul_en;
    logic      acc_en;
    logic      div_load;
    logic      div_step;
  } ovn_cmd_t;

  typedef struct packed {
    logic last_oct;
  } ovn_stat_t;

endpackage

// File: rtl/core/octave_value_noise_2d.sv
// Top level of the octave value noise block.
// Depends on ovn_pkg, ovn_ctrl, ovn_datapath (and ovn_ram below it).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  request  | start in, busy out         | req_type_i, pos_x_i, pos_y_i,
//           |                            | seed_value_i
//  result   | noise_valid_o (1 cycle)    | noise_value_o
//  config   | cfg_we_i, cfg_idx_i        | cfg_data_i
//
// A seed write is taken at the accepting edge and leaves busy low.
// A query walks each octave through the read state (4 seed RAM reads
// through the single registered read port), 3 passes of the shared lerp unit,
// multiply and accumulate, then a divider load and 16 divider steps, then the
// result state; busy stays high through all of it, so the next item is taken
// only once the result state is over.
// Reset clears the sequencer and the config registers; the seed RAM is not
// cleared and must be written before it is read. The result strobe lasts
// exactly one cycle; the receiver takes it unconditionally.
module octave_value_noise_2d
  import ovn_pkg::*;
#(
  parameter int FIELD_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [5:0]        pos_x_i,
  input  logic [5:0]        pos_y_i,
  input  logic [SEED_W-1:0] seed_value_i,
  output logic              noise_valid_o,
  output logic [SEED_W-1:0] noise_value_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);

  ovn_cmd_t  cmd;
  ovn_stat_t stat;

  // sequencer: walks octaves, then the divide
  ovn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_type_i    (req_type_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy          (busy),
    .noise_valid_o (noise_valid_o)
  );

  // seed store, interpolation, weighting and normalization
  ovn_datapath #(
    .FIELD_SIZE(FIELD_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .seed_value_i  (seed_value_i),
    .noise_value_o (noise_value_o)
  );

endmodule

// File: rtl/core/ovn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ovn_ctrl.sv
// Sequencer for the octave value noise block.
// Depends on ovn_pkg; drives the command struct of ovn_datapath.
module ovn_ctrl
  import ovn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      req_type_i,
  input  ovn_stat_t stat_i,
  output ovn_cmd_t  cmd_o,
  output logic      busy,
  output logic      noise_valid_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_LERP  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_ACC   = 8'b0001_0000,
    ST_DIVLD = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [3:0] step_m1;

  assign step_m1 = step_q - 4'd1;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.lerp_sel = LERP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (start) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.seed_we = 1'b1;
          end else begin
            cmd_o.q_load = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        // address k issued at step k, its data captured at the next step
        cmd_o.rd_en   = (step_q < 4'd4);
        cmd_o.rd_sel  = step_q[1:0];
        cmd_o.cap_en  = (step_q != 4'd0);
        cmd_o.cap_sel = step_m1[1:0];
        step_d = step_q + 4'd1;
        if (step_q == 4'd4) begin
          step_d  = '0;
          state_d = ST_LERP;
        end
      end
      ST_LERP: begin
        cmd_o.lerp_en = 1'b1;
        unique case (step_q[1:0])
          2'd0:    cmd_o.lerp_sel = LERP_TOP;
          2'd1:    cmd_o.lerp_sel = LERP_BOT;
          default: cmd_o.lerp_sel = LERP_VER;
        endcase
        step_d = step_q + 4'd1;
        if (step_q == 4'd2) begin
          step_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d = stat_i.last_oct ? ST_DIVLD : ST_READ;
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 4'd1;
        if (step_q == 4'(QUO_W - 1)) begin
          step_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign noise_valid_o = (state_q == ST_OUT);

  // A query keeps the block busy from the next cycle on.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // A seed write finishes in its accept cycle.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_WRITE) |=> !busy)
    else $error("seed write left block busy");

  // One strobe per query, then back to idle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |=> (!noise_valid_o && !busy))
    else $error("result strobe longer than one cycle");

  // The divide only starts after the last octave was accumulated.
  a_div_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |-> $past(cmd_o.acc_en))
    else $error("divide loaded without accumulation");

endmodule

// File: rtl/core/ovn_datapath.sv
// Datapath of the octave value noise block: seed RAM, lerp unit,
// weight/accumulate stage and restoring divider. Depends on ovn_pkg, ovn_ram.
module ovn_datapath
  import ovn_pkg::*;
#(
  parameter int FIELD_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ovn_cmd_t          cmd_i,
  output ovn_stat_t         stat_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [5:0]        pos_x_i,
  input  logic [5:0]        pos_y_i,
  input  logic [SEED_W-1:0] seed_value_i,
  output logic [SEED_W-1:0] noise_value_o
);

  localparam int LG   = $clog2(FIELD_SIZE);
  localparam int AW   = 2 * LG;
  localparam int SH_W = $clog2(LG + 1);
  localparam int LW   = SEED_W + LG + 2;
  localparam logic [SH_W-1:0] LG_V = SH_W'(LG);

  // config registers
  logic [OCT_W-1:0]  oct_cnt_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cnt_q <= OCT_CNT_RST;
      gain_q    <= OCT_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OCT_COUNT: oct_cnt_q <= cfg_data_i[OCT_W-1:0];
        CFG_OCT_GAIN:  gain_q    <= cfg_data_i[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // coordinates, wrapped to the field
  logic [15:0]   px_ext, py_ext;
  logic [LG-1:0] px, py;
  assign px_ext = 16'(pos_x_i);
  assign py_ext = 16'(pos_y_i);
  assign px     = px_ext[LG-1:0];
  assign py     = py_ext[LG-1:0];

  logic [LG-1:0]    x_q, y_q;
  logic [OCT_W-1:0] oct_q, n_q, n_d;

  always_comb begin
    n_d = oct_cnt_q;
    if (oct_cnt_q == '0) begin
      n_d = OCT_W'(1);
    end
    if (int'(n_d) > LG) begin
      n_d = OCT_W'(LG);
    end
  end

  // grid corners of this octave
  logic [LG-1:0]   lowmask, x1, y1, x2, y2, bx, by;
  logic [LG:0]     pitch, x2_full, y2_full;
  logic [SH_W-1:0] shift;

  assign lowmask = {LG{1'b1}} >> oct_q;
  assign pitch   = {1'b0, lowmask} + (LG+1)'(1);
  assign x1      = x_q & ~lowmask;
  assign y1      = y_q & ~lowmask;
  assign bx      = x_q & lowmask;
  assign by      = y_q & lowmask;
  assign x2_full = {1'b0, x1} + pitch;
  assign y2_full = {1'b0, y1} + pitch;
  assign x2      = x2_full[LG-1:0];
  assign y2      = y2_full[LG-1:0];
  assign shift   = LG_V - SH_W'(oct_q);

  // seed RAM
  logic [AW-1:0]     raddr;
  logic [SEED_W-1:0] rdata;

  always_comb begin
    case (cmd_i.rd_sel)
      2'd0:    raddr = {y1, x1};
      2'd1:    raddr = {y1, x2};
      2'd2:    raddr = {y2, x1};
      default: raddr = {y2, x2};
    endcase
  end

  ovn_ram #(
    .WIDTH(SEED_W),
    .DEPTH(FIELD_SIZE * FIELD_SIZE)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seed_we),
    .waddr_i ({py, px}),
    .wdata_i (seed_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [SEED_W-1:0] s0_q, s1_q, s2_q, s3_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_sel)
        2'd0:    s0_q <= rdata;
        2'd1:    s1_q <= rdata;
        2'd2:    s2_q <= rdata;
        default: s3_q <= rdata;
      endcase
    end
  end

  // shared lerp unit: (a*(P-f) + b*f) >> shift
  logic [SEED_W-1:0] la, lb, top_q, bot_q, v_q, lres;
  logic [LG-1:0]     lf;
  logic [LG:0]       lpf;
  logic [LW-1:0]     lsum, lsh;

  always_comb begin
    case (cmd_i.lerp_sel)
      LERP_TOP: begin la = s0_q;  lb = s1_q;  lf = bx; end
      LERP_BOT: begin la = s2_q;  lb = s3_q;  lf = bx; end
      default:  begin la = top_q; lb = bot_q; lf = by; end
    endcase
  end

  assign lpf  = pitch - {1'b0, lf};
  assign lsum = LW'(la) * LW'(lpf) + LW'(lb) * LW'(lf);
  assign lsh  = lsum >> shift;
  assign lres = lsh[SEED_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_en) begin
      case (cmd_i.lerp_sel)
        LERP_TOP: top_q <= lres;
        LERP_BOT: bot_q <= lres;
        LERP_VER: v_q   <= lres;
        default:  ;
      endcase
    end
  end

  // weight, product and accumulators
  logic [WGT_W-1:0]          weight_q, wnext_q;
  logic [SEED_W+WGT_W-1:0]   prod_q;
  logic [GAIN_W+WGT_W-1:0]   wgain;
  logic [ACC_W-1:0]          acc_q;
  logic [WS_W-1:0]           wsum_q;

  assign wgain = (GAIN_W+WGT_W)'(weight_q) * (GAIN_W+WGT_W)'(gain_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      x_q      <= px;
      y_q      <= py;
      n_q      <= n_d;
      oct_q    <= '0;
      weight_q <= WGT_ONE;
      acc_q    <= '0;
      wsum_q   <= '0;
    end else begin
      if (cmd_i.mul_en) begin
        prod_q  <= (SEED_W+WGT_W)'(v_q) * (SEED_W+WGT_W)'(weight_q);
        wnext_q <= wgain[WGT_W+FRAC_SH-1:FRAC_SH];
      end
      if (cmd_i.acc_en) begin
        acc_q    <= acc_q + ACC_W'(prod_q);
        wsum_q   <= wsum_q + WS_W'(weight_q);
        weight_q <= wnext_q;
        oct_q    <= oct_q + OCT_W'(1);
      end
    end
  end

  assign stat_o.last_oct = ((oct_q + OCT_W'(1)) == n_q);

  // restoring divide, one quotient bit per step
  logic [ACC_W:0]     num;
  logic [WS_W-1:0]    rem_q;
  logic [QUO_W-1:0]   nlo_q, quo_q;
  logic [WS_W:0]      trial, diff;

  assign num   = {1'b0, acc_q} + (ACC_W+1)'(wsum_q >> 1);
  assign trial = {rem_q, nlo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, wsum_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= num[WS_W+QUO_W-1:QUO_W];
      nlo_q <= num[QUO_W-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
      if (!diff[WS_W]) begin
        rem_q <= diff[WS_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[WS_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign noise_value_o = quo_q;

endmodule

// File: dv/ovn_checker.sv
// Scoreboard for the octave value noise block: tracks seeds and config,
// predicts each query's noise value and compares results. Depends on ovn_pkg.
module ovn_checker
  import ovn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              req_type_i,
  input  logic [5:0]        pos_x_i,
  input  logic [5:0]        pos_y_i,
  input  logic [SEED_W-1:0] seed_value_i,
  input  logic              noise_valid_i,
  input  logic [SEED_W-1:0] noise_value_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output int                fail_cnt_o,
  output int                pending_cnt_o,
  output int                noise_cnt_o
);

  localparam int LOG_SIZE = 6;

  logic [SEED_W-1:0] seed_mem [4096];
  logic [OCT_W-1:0]  oct_cnt;
  logic [GAIN_W-1:0] oct_gain;
  logic [SEED_W-1:0] noise_exp_q[$];

  assign pending_cnt_o = noise_exp_q.size();

  function automatic logic [63:0] lerp_shift(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] frac, int sh);
    logic [63:0] span;
    span = 64'd1 << sh;
    return (a * (span - frac) + b * frac) >> sh;
  endfunction

  function automatic logic [SEED_W-1:0] predict_noise(int x, int y);
    logic [63:0] wgt, acc, wsum, top, bot, v;
    int n, sh, p, x1, y1, x2, y2;
    n = (oct_cnt == 0) ? 1 : int'(oct_cnt);
    if (n > LOG_SIZE) n = LOG_SIZE;
    wgt  = 64'd4096;
    acc  = '0;
    wsum = '0;
    for (int o = 0; o < n; o++) begin
      sh = LOG_SIZE - o;
      p  = 1 << sh;
      x1 = x & ~(p - 1);
      y1 = y & ~(p - 1);
      x2 = (x1 + p) % 64;
      y2 = (y1 + p) % 64;
      top = lerp_shift(64'(seed_mem[y1*64+x1]), 64'(seed_mem[y1*64+x2]),
                       64'(x - x1), sh);
      bot = lerp_shift(64'(seed_mem[y2*64+x1]), 64'(seed_mem[y2*64+x2]),
                       64'(x - x1), sh);
      v   = lerp_shift(top, bot, 64'(y - y1), sh);
      acc  += v * wgt;
      wsum += wgt;
      wgt = (wgt * 64'(oct_gain)) >> FRAC_SH;
    end
    return SEED_W'((acc + wsum / 2) / wsum);
  endfunction

  task automatic report(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o  = 0;
    noise_cnt_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SEED_W-1:0] exp_val;
    if (!rst_ni) begin
      oct_cnt  <= OCT_CNT_RST;
      oct_gain <= OCT_GAIN_RST;
      noise_exp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_OCT_COUNT) oct_cnt <= cfg_data_i[OCT_W-1:0];
        else oct_gain <= cfg_data_i;
      end
      if (start_i && !busy_i) begin
        if (req_type_i == REQ_WRITE) seed_mem[{pos_y_i, pos_x_i}] = seed_value_i;
        else noise_exp_q.push_back(predict_noise(pos_x_i, pos_y_i));
      end
      if (noise_valid_i) begin
        noise_cnt_o++;
        if (noise_exp_q.size() == 0) begin
          report($sformatf("noise result %h with no query waiting", noise_value_i));
        end else begin
          exp_val = noise_exp_q.pop_front();
          if (noise_value_i !== exp_val)
            report($sformatf("noise_value got %h, want %h", noise_value_i, exp_val));
        end
      end
    end
  end

endmodule

// File: dv/tb_octave_value_noise_2d.sv
// Testbench top for octave_value_noise_2d: clock, reset, seed/query stimulus,
// config phases and the verdict. Depends on ovn_pkg, ovn_checker and the RTL.
module tb_octave_value_noise_2d;
  import ovn_pkg::*;

  localparam int ITEM_GOAL   = 1950;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_PHASES  = 6;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              req_type_i;
  logic [5:0]        pos_x_i;
  logic [5:0]        pos_y_i;
  logic [SEED_W-1:0] seed_value_i;
  logic              noise_valid_o;
  logic [SEED_W-1:0] noise_value_o;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [15:0]       cfg_data_i;

  int fail_cnt, pending_cnt, noise_cnt;
  int item_cnt;
  int idle_pct;
  int cycle_cnt;
  int cur_oct;         // octave count as the block will use it
  bit seeded [4096];   // seed entries written so far

  octave_value_noise_2d #(.FIELD_SIZE(64)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .pos_x_i, .pos_y_i,
    .seed_value_i, .noise_valid_o, .noise_value_o, .cfg_we_i,
    .cfg_idx_i(cfg_idx_i), .cfg_data_i
  );

  ovn_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_type_i, .pos_x_i,
    .pos_y_i, .seed_value_i, .noise_valid_i(noise_valid_o),
    .noise_value_i(noise_value_o), .cfg_we_i, .cfg_idx_i(cfg_idx_i),
    .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_cnt_o(pending_cnt),
    .noise_cnt_o(noise_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item at a falling edge, maybe after a random gap, and hold it
  // until the block takes it. Start stays high on return so that back-to-back
  // items never drop it.
  task automatic send_item(logic rtype, int x, int y, logic [15:0] seed);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= rtype;
    pos_x_i      <= 6'(x);
    pos_y_i      <= 6'(y);
    seed_value_i <= seed;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (rtype == REQ_WRITE) seeded[y*64 + x] = 1'b1;
    item_cnt++;
  endtask

  function automatic logic [15:0] rand_seed();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Write every grid corner the query at (x,y) will read that is still unset.
  task automatic seed_corners(int x, int y);
    int sh, p, x1, y1, xs[2], ys[2];
    for (int o = 0; o < cur_oct; o++) begin
      sh = 6 - o;
      p  = 1 << sh;
      x1 = x & ~(p - 1);
      y1 = y & ~(p - 1);
      xs[0] = x1; xs[1] = (x1 + p) % 64;
      ys[0] = y1; ys[1] = (y1 + p) % 64;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          if (!seeded[ys[i]*64 + xs[j]]) send_item(REQ_WRITE, xs[j], ys[i], rand_seed());
    end
  endtask

  task automatic query_at(int x, int y);
    seed_corners(x, y);
    send_item(REQ_QUERY, x, y, 16'($urandom));
  endtask

  // Drop start, let every query drain, then allow the worst-case latency.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0 || busy);
    repeat (90) @(posedge clk_i);
  endtask

  // Registers are only written with the block drained.
  task automatic write_cfg(cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    start      <= 1'b0;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OCT_COUNT) begin
      cur_oct = (data[2:0] == 0) ? 1 : int'(data[2:0]);
      if (cur_oct > 6) cur_oct = 6;
    end
  endtask

  initial begin
    logic [2:0]  phase_cnt  [NUM_PHASES];
    logic [15:0] phase_gain [NUM_PHASES];
    int phase_idle [NUM_PHASES];
    int goal;

    phase_cnt  = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd5};
    phase_idle = '{21, 21, 54, 54, 0, 0};
    phase_gain = '{16'd2048, 16'hFFFF, 16'd0, 16'd4096, 16'($urandom), 16'($urandom)};
    start = 1'b0; req_type_i = REQ_WRITE; pos_x_i = '0; pos_y_i = '0;
    seed_value_i = '0; cfg_we_i = 1'b0; cfg_idx_i = CFG_OCT_COUNT; cfg_data_i = '0;
    cycle_cnt = 0; item_cnt = 0; idle_pct = 0; cur_oct = 1;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field corners, extreme seeds, full octave depth, reset config.
    send_item(REQ_WRITE, 0, 0, 16'hFFFF);
    send_item(REQ_WRITE, 63, 63, 16'hFFFF);
    query_at(0, 0);
    drain();
    write_cfg(CFG_OCT_COUNT, 16'd7);   // saturates at six octaves
    send_item(REQ_WRITE, 0, 0, 16'h0000);
    query_at(0, 0);
    query_at(63, 63);
    query_at(63, 0);
    query_at(0, 63);
    query_at(1, 1);
    query_at(31, 32);
    drain();
    write_cfg(CFG_OCT_COUNT, 16'd0);   // zero means one octave
    query_at(33, 17);
    query_at(62, 1);
    drain();

    // Random phases, each with its own register setting and an idle rate from phase_idle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_cfg(CFG_OCT_COUNT, {13'd0, phase_cnt[ph]});
      write_cfg(CFG_OCT_GAIN, phase_gain[ph]);
      idle_pct = phase_idle[ph];
      goal = item_cnt + ITEM_GOAL / NUM_PHASES;
      while (item_cnt < goal) begin
        if ($urandom_range(99) < 30)
          send_item(REQ_WRITE, $urandom_range(63), $urandom_range(63), rand_seed());
        else
          query_at($urandom_range(63), $urandom_range(63));
      end
      drain();
    end

    $display("covered %0d items and %0d noise results over %0d config phases",
             item_cnt, noise_cnt, NUM_PHASES);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
